[sv/rcd_pkg.sv]
// ----------------------------------------------------------------------------
// rcd_pkg: shared types, codes and calendar helpers
// Register indexes, request kinds, the configuration bundle, the interface
// between the clock core and the date sequencer, and month tables.
// ----------------------------------------------------------------------------
package rcd_pkg;

    // Default build values
    localparam int ACC_BITS_DEF         = 24;
    localparam int TICKS_PER_SECOND_DEF = 64;
    localparam int DST_CHANGE_HOUR_DEF  = 2;
    localparam int START_YEAR_DEF       = 2019;

    localparam int PHASE_W  = 24;
    localparam int CFG_IDX_W = 4;

    // Request kinds carried in tuser
    typedef enum logic [1:0] {
        ACT_TICK     = 2'd0,
        ACT_SET_TIME = 2'd1,
        ACT_SET_DATE = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_INC   = 4'd0,
        REG_HOUR_MIN    = 4'd1,
        REG_HOUR_MAX    = 4'd2,
        REG_DST_ENABLE  = 4'd3,
        REG_START_MONTH = 4'd4,
        REG_START_WEEK  = 4'd5,
        REG_END_MONTH   = 4'd6,
        REG_END_WEEK    = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_inc;
        logic               hour_min;
        logic [4:0]         hour_max;
        logic               dst_en;
        logic [3:0]         start_month;
        logic [2:0]         start_week;
        logic [3:0]         end_month;
        logic [2:0]         end_week;
    } cfg_t;

    // Date sequencer states
    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_MUL  = 2'd1,
        SEQ_SUM  = 2'd2,
        SEQ_DAY  = 2'd3
    } seq_state_t;

    typedef struct packed {
        logic        start;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } seq_req_t;

    typedef struct packed {
        logic       busy;
        logic       done;
        logic       leap;
        logic [2:0] wday;
        logic [4:0] start_day;
        logic [4:0] stop_day;
    } seq_res_t;

    localparam logic [4:0] MONTH_LEN [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };

    localparam logic [2:0] SAK_OFF [16] = '{
        3'd0, 3'd0, 3'd3, 3'd2, 3'd5, 3'd0, 3'd3, 3'd5,
        3'd1, 3'd4, 3'd6, 3'd2, 3'd4, 3'd0, 3'd0, 3'd0
    };

    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        return (m == 4'd2 && leap) ? 5'd29 : MONTH_LEN[m];
    endfunction

    // Elaboration-time helpers for reset values
    function automatic int leap_of(input int y);
        return ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 1 : 0;
    endfunction

    function automatic int jan1_weekday(input int y);
        int yy;
        yy = y + 399;
        return (yy + yy / 4 - yy / 100 + yy / 400 + 1) % 7;
    endfunction

endpackage

[sv/rcd_regs.sv]
// ----------------------------------------------------------------------------
// rcd_regs: configuration register file
// Takes one register write per request and presents all settings as a bundle.
// ----------------------------------------------------------------------------
module rcd_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rcd_pkg::PHASE_W-1:0]   cfg_data,
    output rcd_pkg::cfg_t                 cfg
);

    rcd_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the write and update the addressed register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.phase_inc   <= '0;
            cfg_reg.hour_min    <= 1'b0;
            cfg_reg.hour_max    <= 5'd23;
            cfg_reg.dst_en      <= 1'b0;
            cfg_reg.start_month <= 4'd3;
            cfg_reg.start_week  <= 3'd2;
            cfg_reg.end_month   <= 4'd11;
            cfg_reg.end_week    <= 3'd1;
        end else if (cfg_valid) begin
            unique case (rcd_pkg::cfg_reg_t'(cfg_index))
                rcd_pkg::REG_PHASE_INC:   cfg_reg.phase_inc   <= cfg_data;
                rcd_pkg::REG_HOUR_MIN:    cfg_reg.hour_min    <= cfg_data[0];
                rcd_pkg::REG_HOUR_MAX:    cfg_reg.hour_max    <= cfg_data[4:0];
                rcd_pkg::REG_DST_ENABLE:  cfg_reg.dst_en      <= cfg_data[0];
                rcd_pkg::REG_START_MONTH: cfg_reg.start_month <= cfg_data[3:0];
                rcd_pkg::REG_START_WEEK:  cfg_reg.start_week  <= cfg_data[2:0];
                rcd_pkg::REG_END_MONTH:   cfg_reg.end_month   <= cfg_data[3:0];
                rcd_pkg::REG_END_WEEK:    cfg_reg.end_week    <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

endmodule

[sv/rcd_dateseq.sv]
// ----------------------------------------------------------------------------
// rcd_dateseq: date sequencer
// Works out the leap flag, the weekday of a date and the two DST Sundays
// for a year: divide by 100 through a reciprocal multiply, fold the
// Gregorian day count modulo 7, then place the nth Sundays.
// ----------------------------------------------------------------------------
module rcd_dateseq (
    input  logic              aclk,
    input  logic              aresetn,
    input  rcd_pkg::cfg_t     cfg,
    input  rcd_pkg::seq_req_t req,
    output rcd_pkg::seq_res_t res
);

    localparam logic [14:0] YEAR_BIAS = 15'd400;
    localparam logic [27:0] RECIP_100 = 28'd5243;

    rcd_pkg::seq_state_t state_reg, state_next;

    logic [14:0] yy_reg;
    logic [3:0]  mon_reg;
    logic [4:0]  day_reg;
    logic [7:0]  q100_reg;
    logic        leap_reg;
    logic [2:0]  w0_reg;
    logic [2:0]  w1_reg;

    logic [27:0] prod;
    logic [14:0] rem100;
    logic [15:0] day_sum;
    logic        by4, by100, by400, leap_calc;
    logic [2:0]  w0_calc;
    logic [3:0]  w1_sum;

    // Residue modulo 7 by folding octal digits
    function automatic logic [2:0] mod7(input logic [15:0] v);
        logic [17:0] x;
        logic [5:0]  s1;
        logic [3:0]  s2;
        x  = {2'b00, v};
        s1 = '0;
        for (int i = 0; i < 6; i++) begin
            s1 = s1 + 6'(x[3*i +: 3]);
        end
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
        return (s2 >= 4'd7) ? 3'(s2 - 4'd7) : s2[2:0];
    endfunction

    // January and February count from the year before
    function automatic logic [2:0] base_of(input logic [3:0] m, input logic [2:0] w0,
                                           input logic [2:0] w1);
        return (m < 4'd3) ? w1 : w0;
    endfunction

    // nth Sunday of month m, clamped week, last Sunday when the fifth overruns
    function automatic logic [4:0] nth_sunday(input logic [3:0] m, input logic [2:0] wk,
                                              input logic [2:0] w0, input logic [2:0] w1,
                                              input logic leap);
        logic [2:0] wd1;
        logic [2:0] wkc;
        logic [3:0] first;
        logic [5:0] d;
        wd1   = mod7(16'(base_of(m, w0, w1)) + 16'(rcd_pkg::SAK_OFF[m]) + 16'd1);
        wkc   = (wk == 3'd0) ? 3'd1 : ((wk > 3'd5) ? 3'd5 : wk);
        first = (wd1 == 3'd0) ? 4'd1 : 4'(4'd8 - 4'(wd1));
        d     = 6'(first) + 6'd7 * 6'(wkc - 3'd1);
        if (d > 6'(rcd_pkg::month_days(m, leap))) begin
            d = d - 6'd7;
        end
        if (m < 4'd1 || m > 4'd12) begin
            d = '0;
        end
        return d[4:0];
    endfunction

    // Next-state logic
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rcd_pkg::SEQ_IDLE: if (req.start) state_next = rcd_pkg::SEQ_MUL;
            rcd_pkg::SEQ_MUL:  state_next = rcd_pkg::SEQ_SUM;
            rcd_pkg::SEQ_SUM:  state_next = rcd_pkg::SEQ_DAY;
            rcd_pkg::SEQ_DAY:  state_next = rcd_pkg::SEQ_IDLE;
            default:           state_next = rcd_pkg::SEQ_IDLE;
        endcase
    end

    // Day count of the biased year and its residues
    always_comb begin
        prod      = 28'(yy_reg) * RECIP_100;
        rem100    = yy_reg - 15'(q100_reg) * 15'd100;
        by4       = (yy_reg[1:0] == 2'b00);
        by100     = (rem100 == 15'd0);
        by400     = by100 && (q100_reg[1:0] == 2'b00);
        leap_calc = by4 && (!by100 || by400);
        day_sum   = 16'(yy_reg) + 16'(yy_reg >> 2) - 16'(q100_reg) + 16'(q100_reg >> 2);
        w0_calc   = mod7(day_sum);
        // one year earlier: one day less, and one more in a leap year
        w1_sum    = 4'(w0_calc) + 4'd6 - 4'(leap_calc);
    end

    // Output logic
    always_comb begin
        res.busy      = (state_reg != rcd_pkg::SEQ_IDLE);
        res.done      = (state_reg == rcd_pkg::SEQ_DAY);
        res.leap      = leap_reg;
        res.wday      = mod7(16'(base_of(mon_reg, w0_reg, w1_reg))
                             + 16'(rcd_pkg::SAK_OFF[mon_reg]) + 16'(day_reg));
        res.start_day = nth_sunday(cfg.start_month, cfg.start_week, w0_reg, w1_reg, leap_reg);
        res.stop_day  = nth_sunday(cfg.end_month, cfg.end_week, w0_reg, w1_reg, leap_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rcd_pkg::SEQ_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Hold the request, then the quotient, then the weekday bases
    always_ff @(posedge aclk) begin
        if (state_reg == rcd_pkg::SEQ_IDLE && req.start) begin
            yy_reg  <= 15'(req.year) + YEAR_BIAS;
            mon_reg <= req.month;
            day_reg <= req.day;
        end
        if (state_reg == rcd_pkg::SEQ_MUL) begin
            q100_reg <= prod[26:19];
        end
        if (state_reg == rcd_pkg::SEQ_SUM) begin
            leap_reg <= leap_calc;
            w0_reg   <= w0_calc;
            w1_reg   <= (w1_sum >= 4'd7) ? 3'(w1_sum - 4'd7) : w1_sum[2:0];
        end
    end

endmodule

[sv/rtc_calendar_dst_top.sv]
// ----------------------------------------------------------------------------
// rtc_calendar_dst_top: real-time clock and calendar with daylight saving
// Phase-accumulator time base, calendar counters and DST hour changes.
// ----------------------------------------------------------------------------
// Usage:
//  s_ channel: one request per beat, kind in s_tuser (tick, set time,
//  set date). m_ channel: one result per request with the time and date
//  after it. cfg_ channel writes the settings; write only while idle.
//  Ticks and set-time requests: the result is registered and appears in the
//  cycle after acceptance, and a new request can be taken every cycle while
//  the output is not stalled and the date sequencer is idle. A set-date
//  request runs the date sequencer (multiply, fold, place Sundays), then
//  marks a DST fix pending and loads its result from that; the input is
//  held off meanwhile. A tick that rolls over the year reports at once and
//  then holds off the input while the leap flag and DST days are recomputed.
//  Reset starts at 00:00:00 on January 1 of START_YEAR, DST off.
//  When the receiver stalls, the result stays in the output register and a
//  new request is taken only in a cycle where that register is emptied.
// ----------------------------------------------------------------------------
module rtc_calendar_dst_top #(
    parameter int ACC_BITS         = rcd_pkg::ACC_BITS_DEF,
    parameter int TICKS_PER_SECOND = rcd_pkg::TICKS_PER_SECOND_DEF,
    parameter int DST_CHANGE_HOUR  = rcd_pkg::DST_CHANGE_HOUR_DEF,
    parameter int START_YEAR       = rcd_pkg::START_YEAR_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // new_hour, new_minute, new_second, new_day, new_month, new_year
    input  logic [39:0]                   s_tdata,
    // action
    input  logic [1:0]                    s_tuser,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // hour_now, minute_now, second_now, day_now, month_now, year_now,
    // weekday_now, dst_active_now, second_pulse, half_second_pulse
    output logic [47:0]                   m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rcd_pkg::PHASE_W-1:0]   cfg_data
);

    localparam int SUM_W = ((ACC_BITS > rcd_pkg::PHASE_W) ? ACC_BITS : rcd_pkg::PHASE_W) + 1;
    localparam int SUB_W = $clog2(TICKS_PER_SECOND);
    localparam logic [SUB_W-1:0] SUB_TOP  = SUB_W'(TICKS_PER_SECOND - 1);
    localparam logic [SUB_W-1:0] SUB_HALF = SUB_W'(TICKS_PER_SECOND / 2);
    localparam logic [5:0]  CHANGE_HOUR = 6'(DST_CHANGE_HOUR);
    localparam logic [2:0]  RESET_WDAY  = 3'(rcd_pkg::jan1_weekday(START_YEAR));
    localparam logic        RESET_LEAP  = 1'(rcd_pkg::leap_of(START_YEAR));

    rcd_pkg::cfg_t     cfg;
    rcd_pkg::seq_req_t seq_req;
    rcd_pkg::seq_res_t seq_res;

    logic [ACC_BITS-1:0] acc_reg, acc_next;
    logic [SUB_W-1:0]    sub_reg, sub_next;
    logic [5:0]          sec_reg, sec_next;
    logic [5:0]          min_reg, min_next;
    logic [4:0]          hour_reg, hour_next;
    logic [4:0]          day_reg, day_next;
    logic [3:0]          mon_reg, mon_next;
    logic [13:0]         year_reg, year_next;
    logic [2:0]          wday_reg, wday_next;
    logic                leap_reg;
    logic [4:0]          start_day_reg, stop_day_reg;
    logic                dst_reg, dst_next;
    logic                sec_pulse, half_pulse, rollover;
    logic                date_pend_reg, fix_pend_reg;
    logic                m_tvalid_reg;
    logic [47:0]         m_tdata_reg;

    logic             accept, out_free, fix_load, fix_now;
    rcd_pkg::action_t action;
    logic [4:0]       in_hour, in_day;
    logic [5:0]       in_min, in_sec;
    logic [3:0]       in_mon;
    logic [13:0]      in_year;

    rcd_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rcd_dateseq u_dateseq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .req     (seq_req),
        .res     (seq_res)
    );

    assign action  = rcd_pkg::action_t'(s_tuser);
    assign in_hour = s_tdata[4:0];
    assign in_min  = s_tdata[10:5];
    assign in_sec  = s_tdata[16:11];
    assign in_day  = s_tdata[21:17];
    assign in_mon  = s_tdata[25:22];
    assign in_year = s_tdata[39:26];

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = !seq_res.busy && !fix_pend_reg && out_free;
    assign accept   = s_tvalid && s_tready;
    assign fix_load = fix_pend_reg && out_free;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // DST state implied by a date and time
    function automatic logic fix_dst(input rcd_pkg::cfg_t c, input logic [3:0] mo,
                                     input logic [4:0] dd, input logic [4:0] h,
                                     input logic [5:0] mi, input logic [5:0] s,
                                     input logic [4:0] sd, input logic [4:0] ed);
        logic signed [11:0] c_start, c_end;
        logic signed [19:0] c_time;
        logic               r;
        c_start = ($signed({8'd0, mo}) - $signed({8'd0, c.start_month})) * 12'sd31
                  + ($signed({7'd0, dd}) - $signed({7'd0, sd}));
        c_end   = ($signed({8'd0, mo}) - $signed({8'd0, c.end_month})) * 12'sd31
                  + ($signed({7'd0, dd}) - $signed({7'd0, ed}));
        c_time  = ($signed({15'd0, h}) - $signed(20'(DST_CHANGE_HOUR))) * 20'sd3600
                  + $signed({14'd0, mi}) * 20'sd60 + $signed({14'd0, s});
        if (c_start < 0) begin
            r = 1'b0;
        end else if (c_start == 0) begin
            r = (c_time >= 0);
        end else if (c_end < 0) begin
            r = 1'b1;
        end else if (c_end == 0) begin
            r = (c_time < 0);
        end else begin
            r = 1'b0;
        end
        return c.dst_en && r;
    endfunction

    // Advance the time base and calendar for one request
    always_comb begin : step_calc
        logic [SUM_W-1:0] sum;
        logic [6:0]       s7;
        logic [6:0]       m7;
        logic [5:0]       h6;
        acc_next   = acc_reg;
        sub_next   = sub_reg;
        sec_next   = sec_reg;
        min_next   = min_reg;
        hour_next  = hour_reg;
        day_next   = day_reg;
        mon_next   = mon_reg;
        year_next  = year_reg;
        wday_next  = wday_reg;
        dst_next   = dst_reg;
        sec_pulse  = 1'b0;
        half_pulse = 1'b0;
        rollover   = 1'b0;
        sum        = SUM_W'(acc_reg) + SUM_W'(cfg.phase_inc);
        s7         = 7'(sec_reg) + 7'd1;
        m7         = 7'(min_reg) + 7'd1;
        h6         = 6'(hour_reg);
        case (action)
            rcd_pkg::ACT_TICK: begin
                acc_next = sum[ACC_BITS-1:0];
                if (sum[ACC_BITS]) begin
                    if (sub_reg != '0) begin
                        half_pulse = (sub_reg == SUB_HALF);
                        sub_next   = sub_reg - SUB_W'(1);
                    end else begin
                        sub_next  = SUB_TOP;
                        sec_pulse = 1'b1;
                        if (s7 > 7'd59) begin
                            sec_next = '0;
                            if (m7 > 7'd59) begin
                                min_next = '0;
                                h6       = h6 + 6'd1;
                                // move the hour on the DST change days
                                if (cfg.dst_en && h6 == CHANGE_HOUR) begin
                                    if (dst_reg) begin
                                        if (mon_reg == cfg.end_month
                                            && day_reg == stop_day_reg) begin
                                            h6       = h6 - 6'd1;
                                            dst_next = 1'b0;
                                        end
                                    end else if (mon_reg == cfg.start_month
                                                 && day_reg == start_day_reg) begin
                                        h6       = h6 + 6'd1;
                                        dst_next = 1'b1;
                                    end
                                end
                            end else begin
                                min_next = m7[5:0];
                            end
                            if (h6 > 6'(cfg.hour_max)) begin
                                hour_next = 5'(cfg.hour_min);
                                wday_next = (wday_reg < 3'd6) ? wday_reg + 3'd1 : 3'd0;
                                if (day_reg < rcd_pkg::month_days(mon_reg, leap_reg)) begin
                                    day_next = day_reg + 5'd1;
                                end else begin
                                    day_next = 5'd1;
                                    if (mon_reg < 4'd12) begin
                                        mon_next = mon_reg + 4'd1;
                                    end else begin
                                        mon_next  = 4'd1;
                                        year_next = year_reg + 14'd1;
                                        rollover  = 1'b1;
                                    end
                                end
                            end else begin
                                hour_next = h6[4:0];
                            end
                        end else begin
                            sec_next = s7[5:0];
                        end
                    end
                end
            end
            rcd_pkg::ACT_SET_TIME: begin
                hour_next = in_hour;
                min_next  = in_min;
                sec_next  = in_sec;
                sub_next  = SUB_TOP;
                dst_next  = fix_dst(cfg, mon_reg, day_reg, in_hour, in_min, in_sec,
                                    start_day_reg, stop_day_reg);
            end
            rcd_pkg::ACT_SET_DATE: begin
                day_next  = in_day;
                mon_next  = in_mon;
                year_next = in_year;
            end
            default: ;
        endcase
    end

    assign fix_now = fix_dst(cfg, mon_reg, day_reg, hour_reg, min_reg, sec_reg,
                             start_day_reg, stop_day_reg);

    // Start the sequencer on a set date or a year rollover
    always_comb begin
        seq_req.start = accept && (action == rcd_pkg::ACT_SET_DATE || rollover);
        seq_req.year  = year_next;
        seq_req.month = mon_next;
        seq_req.day   = day_next;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            date_pend_reg <= 1'b0;
            fix_pend_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                date_pend_reg <= (action == rcd_pkg::ACT_SET_DATE);
            end
            if (seq_res.done) begin
                fix_pend_reg <= date_pend_reg;
            end else if (fix_load) begin
                fix_pend_reg <= 1'b0;
            end
            if ((accept && action != rcd_pkg::ACT_SET_DATE) || fix_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Clock and calendar state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            sub_reg       <= '0;
            sec_reg       <= '0;
            min_reg       <= '0;
            hour_reg      <= '0;
            day_reg       <= 5'd1;
            mon_reg       <= 4'd1;
            year_reg      <= 14'(START_YEAR);
            wday_reg      <= RESET_WDAY;
            leap_reg      <= RESET_LEAP;
            start_day_reg <= '0;
            stop_day_reg  <= '0;
            dst_reg       <= 1'b0;
        end else begin
            if (accept) begin
                acc_reg  <= acc_next;
                sub_reg  <= sub_next;
                sec_reg  <= sec_next;
                min_reg  <= min_next;
                hour_reg <= hour_next;
                day_reg  <= day_next;
                mon_reg  <= mon_next;
                year_reg <= year_next;
                wday_reg <= wday_next;
                dst_reg  <= dst_next;
            end
            if (seq_res.done) begin
                leap_reg <= seq_res.leap;
                if (date_pend_reg) begin
                    wday_reg <= seq_res.wday;
                end
                if (cfg.dst_en) begin
                    start_day_reg <= seq_res.start_day;
                    stop_day_reg  <= seq_res.stop_day;
                end
            end
            if (fix_load) begin
                dst_reg <= fix_now;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (accept && action != rcd_pkg::ACT_SET_DATE) begin
            m_tdata_reg <= {2'b00, half_pulse, sec_pulse, dst_next, wday_next, year_next,
                            mon_next, day_next, sec_next, min_next, hour_next};
        end else if (fix_load) begin
            m_tdata_reg <= {2'b00, 1'b0, 1'b0, fix_now, wday_reg, year_reg,
                            mon_reg, day_reg, sec_reg, min_reg, hour_reg};
        end
    end

    // Checks
    assert property (@(posedge aclk) disable iff (!aresetn)
        fix_pend_reg |-> !seq_res.busy)
        else $error("DST fix pending while the date sequencer runs");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && action == rcd_pkg::ACT_SET_DATE) |=> (seq_res.busy && date_pend_reg))
        else $error("set date did not start the date sequencer");

    assert property (@(posedge aclk) disable iff (!aresetn)
        seq_res.busy |-> !s_tready)
        else $error("request taken while the date sequencer runs");

    assert property (@(posedge aclk) disable iff (!aresetn)
        sub_reg <= SUB_TOP)
        else $error("sub-second count out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        seq_res.done |=> (fix_pend_reg == $past(date_pend_reg)))
        else $error("DST fix not scheduled after set date");

endmodule
